### src/hcbd_pkg.sv
// hcbd_pkg: types and constants for the chunked body decoder.
// Used by hcbd_front, hcbd_queue, hcbd_back and http_chunked_body_decoder.
package hcbd_pkg;

	localparam int MAX_HEX_DIGITS = 15;
	localparam int DIGIT_W        = $clog2(MAX_HEX_DIGITS + 1);
	localparam int COUNT_W        = 60;
	localparam int HEX_W          = 4;
	localparam int BYTE_W         = 8;
	localparam int STATUS_W       = 3;
	localparam int OUT_TDATA_W    = 16;

	localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

	typedef enum logic [STATUS_W-1:0] {
		PH_DIGITS = 3'd0,
		PH_REST   = 3'd1,
		PH_DATA   = 3'd2,
		PH_AFTER  = 3'd3,
		PH_DONE   = 3'd4,
		PH_BAD    = 3'd5
	} phase_t;

	// classified input beat
	typedef struct packed {
		logic [BYTE_W-1:0] body_byte;
		logic              last;
		logic              is_hex;
		logic [HEX_W-1:0]  hex_val;
		logic              is_cr;
		logic              is_lf;
	} beat_class_t;

endpackage

### src/http_chunked_body_decoder.sv
// http_chunked_body_decoder: top level of the chunked transfer body decoder.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back.
//
//  channel  | dir | tdata                                   | tlast
//  s_axis   | in  | [7:0] body_byte                         | last_of_body
//  m_axis   | out | [0] data_valid, [8:1] data_byte,        | -
//           |     | [11:9] status, [15:12] zero             |
//
// One beat per cycle while m_axis does not stall; a beat taken goes to the front
// register, then is written to the queue, then to the output register. The back
// state update, a 60-bit decrement and zero test, sets the clock path.
// arst_n clears all control state; no clearing pass.
// A stall on m_axis fills the queue and front register, then drops s_axis_tready.
module http_chunked_body_decoder import hcbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] body_byte
	input  logic                   s_axis_tlast,   // last_of_body
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // data_valid, data_byte, status
);

	logic        f_valid;
	logic        f_ready;
	beat_class_t f_item;
	logic        q_valid;
	logic        q_ready;
	beat_class_t q_item;

	hcbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item)
	);

	hcbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	hcbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_item  (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

### src/hcbd_front.sv
// hcbd_front: accepts input beats, decodes hex digit / CR / LF, registers the result.
// Depends on hcbd_pkg.
module hcbd_front import hcbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	output logic              push_valid,
	input  logic              push_ready,
	output beat_class_t       push_item
);

	beat_class_t cls;
	logic        vld_s1;
	beat_class_t item_s1;

	always_comb begin
		cls           = '0;
		cls.body_byte = in_byte;
		cls.last      = in_last;
		cls.is_cr     = (in_byte == BYTE_CR);
		cls.is_lf     = (in_byte == BYTE_LF);
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = HEX_W'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = HEX_W'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = HEX_W'(in_byte - 8'h37);
		end
	end

	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

### src/hcbd_queue.sv
// hcbd_queue: two-entry queue of classified beats between front and back.
// Depends on hcbd_pkg.
module hcbd_queue import hcbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  beat_class_t push_item,
	output logic        pop_valid,
	input  logic        pop_ready,
	output beat_class_t pop_item
);

	beat_class_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/hcbd_back.sv
// hcbd_back: chunk parser state machine and output register.
// Depends on hcbd_pkg.
module hcbd_back import hcbd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  beat_class_t              pop_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_TDATA_W-1:0]   out_data
);

	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [DIGIT_W-1:0]   digits_q, digits_d;
	logic                 after_cr_q, after_cr_d;

	logic                 out_vld_q;
	logic                 dv_q, dv_d;
	logic [BYTE_W-1:0]    db_q, db_d;
	phase_t               st_q;

	logic                 take;
	logic                 run_digit;
	logic [COUNT_W-1:0]   eff_count;
	logic [DIGIT_W-1:0]   eff_digits;
	logic [COUNT_W-1:0]   count_dec;

	assign pop_ready = !out_vld_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign count_dec = count_q - COUNT_W'(1);

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		digits_d   = digits_q;
		after_cr_d = after_cr_q;
		dv_d       = 1'b0;
		db_d       = '0;
		run_digit  = 1'b0;
		eff_count  = count_q;
		eff_digits = digits_q;
		unique case (phase_q)
			PH_DIGITS: begin
				run_digit = 1'b1;
			end
			PH_REST: begin
				if (pop_item.is_lf) phase_d = (count_q == '0) ? PH_DONE : PH_DATA;
			end
			PH_DATA: begin
				dv_d    = 1'b1;
				db_d    = pop_item.body_byte;
				count_d = count_dec;
				if (count_dec == '0) begin
					phase_d    = PH_AFTER;
					after_cr_d = 1'b0;
				end
			end
			PH_AFTER: begin
				if (pop_item.is_cr && !after_cr_q) begin
					after_cr_d = 1'b1;
				end else begin
					phase_d    = PH_DIGITS;
					count_d    = '0;
					digits_d   = '0;
					after_cr_d = 1'b0;
					eff_count  = '0;
					eff_digits = '0;
					run_digit  = !pop_item.is_lf;
				end
			end
			PH_DONE, PH_BAD: begin
			end
			default: begin
				phase_d = PH_BAD;
			end
		endcase

		if (run_digit) begin
			if (pop_item.is_hex) begin
				if (eff_digits >= DIGIT_W'(MAX_HEX_DIGITS)) begin
					phase_d = PH_BAD;
				end else begin
					count_d  = {eff_count[COUNT_W-HEX_W-1:0], pop_item.hex_val};
					digits_d = eff_digits + DIGIT_W'(1);
				end
			end else if (eff_digits == '0) begin
				phase_d = PH_BAD;
			end else if (pop_item.is_lf) begin
				phase_d = (eff_count == '0) ? PH_DONE : PH_DATA;
			end else begin
				phase_d = PH_REST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DIGITS;
			count_q    <= '0;
			digits_q   <= '0;
			after_cr_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (pop_ready) out_vld_q <= pop_valid;
			if (take) begin
				if (pop_item.last) begin
					phase_q    <= PH_DIGITS;
					count_q    <= '0;
					digits_q   <= '0;
					after_cr_q <= 1'b0;
				end else begin
					phase_q    <= phase_d;
					count_q    <= count_d;
					digits_q   <= digits_d;
					after_cr_q <= after_cr_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dv_q <= dv_d;
			db_q <= db_d;
			st_q <= phase_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = {4'b0, st_q, db_q, dv_q};

endmodule

### bench/hcbd_checker.sv
`timescale 1ns / 100ps
// hcbd_checker: watches both streams of the chunked body decoder, predicts each
// output beat from the accepted input beats and compares field by field.
// Depends on hcbd_pkg.
module hcbd_checker import hcbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int PAD_LSB = 1 + BYTE_W + STATUS_W;

	typedef struct packed {
		logic              data_valid;
		logic [BYTE_W-1:0] data_byte;
		phase_t            status;
	} decoded_t;

	decoded_t           decoded_q[$];
	phase_t             phase;
	logic [COUNT_W-1:0] chunk_left;
	logic [DIGIT_W-1:0] digits_seen;
	logic               cr_dropped;

	// [4] set when b is a hex digit, [3:0] its value
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = 8'hFF;
		if (b >= "0" && b <= "9") v = b - "0";
		else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
		else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
		return {v != 8'hFF, v[3:0]};
	endfunction

	task automatic clear_decoder();
		phase       = PH_DIGITS;
		chunk_left  = '0;
		digits_seen = '0;
		cr_dropped  = 1'b0;
	endtask

	task automatic size_line_byte(input logic [BYTE_W-1:0] b);
		logic [4:0] hx;
		hx = hex_digit(b);
		if (hx[4]) begin
			if (digits_seen >= MAX_HEX_DIGITS) begin
				phase = PH_BAD;
			end else begin
				chunk_left  = {chunk_left[COUNT_W-5:0], hx[3:0]};
				digits_seen = digits_seen + 1'b1;
			end
		end else if (digits_seen == 0) begin
			phase = PH_BAD;
		end else if (b == BYTE_LF) begin
			phase = (chunk_left == 0) ? PH_DONE : PH_DATA;
		end else begin
			phase = PH_REST;
		end
	endtask

	task automatic decode_body_byte(input logic [BYTE_W-1:0] b, input logic last_b,
			output decoded_t r);
		r = '0;
		case (phase)
			PH_DIGITS: size_line_byte(b);
			PH_REST: begin
				if (b == BYTE_LF) phase = (chunk_left == 0) ? PH_DONE : PH_DATA;
			end
			PH_DATA: begin
				r.data_valid = 1'b1;
				r.data_byte  = b;
				chunk_left   = chunk_left - 1'b1;
				if (chunk_left == 0) begin
					phase      = PH_AFTER;
					cr_dropped = 1'b0;
				end
			end
			PH_AFTER: begin
				if (b == BYTE_CR && !cr_dropped) begin
					cr_dropped = 1'b1;
				end else begin
					clear_decoder();
					if (b != BYTE_LF) size_line_byte(b);
				end
			end
			PH_DONE, PH_BAD: ;
			default: phase = PH_BAD;
		endcase
		r.status = phase;
		if (last_b) clear_decoder();
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			clear_decoder();
			decoded_q.delete();
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					$error("output beat with nothing expected: tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (m_axis_tdata[0] !== want.data_valid) begin
						$error("data_valid: expected %0d, got %0d", want.data_valid,
							m_axis_tdata[0]);
						mismatches++;
					end
					if (m_axis_tdata[BYTE_W:1] !== want.data_byte) begin
						$error("data_byte: expected %h, got %h", want.data_byte,
							m_axis_tdata[BYTE_W:1]);
						mismatches++;
					end
					if (m_axis_tdata[PAD_LSB-1:BYTE_W+1] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							m_axis_tdata[PAD_LSB-1:BYTE_W+1]);
						mismatches++;
					end
					if (m_axis_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0) begin
						$error("pad: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1:PAD_LSB]);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_body_byte(s_axis_tdata, s_axis_tlast, want);
				decoded_q.push_back(want);
			end
		end
		outstanding = decoded_q.size();
	end

endmodule

### bench/tb_http_chunked_body_decoder.sv
`timescale 1ns / 100ps
// tb_http_chunked_body_decoder: drives chunked bodies, well formed and broken,
// into the decoder with random gaps and back-pressure; hcbd_checker judges output.
// Depends on hcbd_pkg, hcbd_checker and the decoder RTL.
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int BODY_BEATS  = 1700;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AT     = 600;
	localparam int IDLE_PCT    = 11;
	localparam logic [BYTE_W-1:0] SEMI = 8'h3B;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   calm;
	int                     mismatches;
	int                     outstanding;
	int                     beats_sent;
	logic [BYTE_W-1:0]      body_q[$];

	http_chunked_body_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hcbd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic drive_beat(input logic [BYTE_W-1:0] b, input logic last_b);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last_b;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	// last beat marked on the final byte, or on a random byte when cut short
	task automatic send_body(input bit truncate);
		int stop;
		stop = truncate ? $urandom_range(body_q.size() - 1) : body_q.size() - 1;
		for (int i = 0; i <= stop; i++) drive_beat(body_q[i], i == stop);
		body_q.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
	endtask

	task automatic push_size(input logic [COUNT_W-1:0] size, input int ndig);
		logic [3:0] nib;
		for (int i = ndig - 1; i >= 0; i--) begin
			nib = size[i*4 +: 4];
			if (nib < 10) body_q.push_back(8'h30 + nib);
			else if ($urandom_range(1)) body_q.push_back(8'h41 + nib - 8'd10);
			else body_q.push_back(8'h61 + nib - 8'd10);
		end
	endtask

	task automatic push_line_end();
		logic [BYTE_W-1:0] b;
		if ($urandom_range(3) == 0) begin
			body_q.push_back(SEMI);
			repeat ($urandom_range(5)) begin
				b = BYTE_W'($urandom_range(255));
				body_q.push_back(b == BYTE_LF ? 8'h20 : b);
			end
		end
		if ($urandom_range(3) != 0) body_q.push_back(BYTE_CR);
		body_q.push_back(BYTE_LF);
	endtask

	task automatic push_chunked_body();
		int len, min_dig;
		repeat ($urandom_range(4)) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			min_dig = (len > 15) ? 2 : 1;
			push_size(COUNT_W'(len),
				($urandom_range(7) == 0) ? 15 : $urandom_range(min_dig, min_dig + 1));
			push_line_end();
			repeat (len) body_q.push_back(BYTE_W'($urandom_range(255)));
			case ($urandom_range(5))
				0, 1, 2: begin
					body_q.push_back(BYTE_CR);
					body_q.push_back(BYTE_LF);
				end
				3: body_q.push_back(BYTE_LF);
				4: body_q.push_back(BYTE_CR);
				default: ;
			endcase
		end
		push_size('0, $urandom_range(1, 3));
		push_line_end();
		repeat ($urandom_range(6)) body_q.push_back(BYTE_W'($urandom_range(255)));
		body_q.push_back(BYTE_CR);
		body_q.push_back(BYTE_LF);
	endtask

	initial begin
		int kind;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		calm          = 1'b0;
		beats_sent    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sixteen digits of both letter cases
		push_text("abcdefABCDEF0123");
		send_body(0);
		// data extremes, LF-only tail, extension, then a second CR
		push_text("2");
		body_q.push_back(BYTE_LF);
		body_q.push_back(8'h00);
		body_q.push_back(8'hFF);
		body_q.push_back(BYTE_LF);
		push_text("1;e");
		body_q.push_back(BYTE_CR);
		body_q.push_back(BYTE_LF);
		body_q.push_back(8'h5A);
		body_q.push_back(BYTE_CR);
		body_q.push_back(BYTE_CR);
		send_body(0);
		// empty size line
		body_q.push_back(BYTE_CR);
		send_body(0);

		while (beats_sent < BODY_BEATS) begin
			calm <= (beats_sent >= 900 && beats_sent < 1200);
			kind = $urandom_range(99);
			if (kind < 78) begin
				push_chunked_body();
				send_body($urandom_range(7) == 0);
			end else begin
				case (kind % 5)
					0: begin
						repeat ($urandom_range(1, 20))
							body_q.push_back(BYTE_W'($urandom_range(255)));
						send_body($urandom_range(1));
					end
					1: begin
						push_size(COUNT_W'({$urandom, $urandom}), 15);
						push_size(COUNT_W'($urandom_range(15)), 1);
						repeat ($urandom_range(4)) body_q.push_back(BYTE_W'($urandom_range(255)));
						send_body(0);
					end
					2: begin
						push_size({4'($urandom_range(1, 15)), 24'($urandom), $urandom}, 15);
						push_line_end();
						repeat ($urandom_range(1, 20))
							body_q.push_back(BYTE_W'($urandom_range(255)));
						send_body(0);
					end
					3: begin
						body_q.push_back($urandom_range(1) ? BYTE_CR : BYTE_LF);
						repeat ($urandom_range(3)) body_q.push_back(BYTE_W'($urandom_range(255)));
						send_body(0);
					end
					default: begin
						push_chunked_body();
						body_q[$urandom_range(body_q.size() - 1)] = BYTE_W'($urandom_range(255));
						send_body(0);
					end
				endcase
			end
		end

		s_axis_tvalid <= 1'b0;
		calm          <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("http_chunked_body_decoder regression: pass");
		end else begin
			$display("http_chunked_body_decoder regression: fail");
		end
		$finish;
	end

	// sink side; one long hold-off while the source keeps offering beats
	initial begin
		int cyc;
		m_axis_tready = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
			else quiet++;
		end
		$display("http_chunked_body_decoder regression: fail");
		$finish;
	end

endmodule

### filelist.f
src/hcbd_pkg.sv
src/hcbd_front.sv
src/hcbd_queue.sv
src/hcbd_back.sv
src/http_chunked_body_decoder.sv
bench/hcbd_checker.sv
bench/tb_http_chunked_body_decoder.sv
